// ===== hw/rtl/contiguous_fit_allocator_defines.svh =====
// assertion macros for the contiguous fit allocator
`ifndef CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_FIT_ALLOCATOR_DEFINES_SVH

// consequent holds in the same cycle as the antecedent
`define CFA_HOLDS(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("allocator check failed");

// consequent holds in the cycle after the antecedent
`define CFA_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ===== hw/rtl/cfa_pkg.sv =====
// shared types and constants of the contiguous fit allocator
package cfa_pkg;

  localparam int MAX_SEGS_DEF  = 16;
  localparam int ADDR_BITS_DEF = 16;
  localparam int TAG_W         = 8;
  localparam int LEN_W         = 16;
  localparam int PORT_ADDR_W   = 16;
  localparam int POL_W         = 2;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POL_W-1:0] POL_WORST = 2'd2;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_ALLOC  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_APPEND,
    CMD_EXACT,
    CMD_SPLIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [TAG_W-1:0]   tag;
    logic [LEN_W-1:0]   len;
    logic [LEN_W-1:0]   rest;
  } cfa_cmd_t;

endpackage

// ===== hw/rtl/cfa_cell.sv =====
// one segment cell: holds a table entry and one step of the hole search wave
module cfa_cell import cfa_pkg::*; #(
  parameter int CELL_IDX  = 0,
  parameter int MAX_SEGS  = MAX_SEGS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  localparam int IDX_W    = $clog2(MAX_SEGS),
  localparam int CNT_W    = $clog2(MAX_SEGS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfa_cmd_t             cmd,
  input  logic [IDX_W-1:0]     cmd_idx,
  input  logic [ADDR_BITS-1:0] cmd_addr,
  input  logic [CNT_W-1:0]     seg_count,
  input  logic [LEN_W-1:0]     req_len,
  input  logic [POL_W-1:0]     fit_policy,
  input  logic [TAG_W-1:0]     left_owner,
  input  logic [ADDR_BITS-1:0] left_base,
  input  logic [LEN_W-1:0]     left_length,
  input  logic                 left_found,
  input  logic [IDX_W-1:0]     left_idx,
  input  logic [LEN_W-1:0]     left_len,
  input  logic [ADDR_BITS-1:0] left_hbase,
  output logic [TAG_W-1:0]     owner,
  output logic [ADDR_BITS-1:0] base,
  output logic [LEN_W-1:0]     length,
  output logic                 best_found,
  output logic [IDX_W-1:0]     best_idx,
  output logic [LEN_W-1:0]     best_len,
  output logic [ADDR_BITS-1:0] best_hbase
);

  logic                 in_use;
  logic                 eligible;
  logic                 take_own;
  logic                 is_target;
  logic                 is_after;
  logic                 is_beyond;
  logic [TAG_W-1:0]     owner_next;
  logic [ADDR_BITS-1:0] base_next;
  logic [LEN_W-1:0]     length_next;

  // search step
  assign in_use   = CNT_W'(CELL_IDX) < seg_count;
  assign eligible = in_use && (owner == '0) && (length >= req_len);

  always_comb begin
    priority if (!eligible) begin
      take_own = 1'b0;
    end else if (!left_found) begin
      take_own = 1'b1;
    end else if (fit_policy == POL_BEST) begin
      take_own = length < left_len;
    end else if (fit_policy == POL_WORST) begin
      take_own = length > left_len;
    end else begin
      take_own = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
    end else begin
      best_found <= left_found || eligible;
    end
  end

  always_ff @(posedge clk) begin
    if (take_own) begin
      best_idx   <= IDX_W'(CELL_IDX);
      best_len   <= length;
      best_hbase <= base;
    end else begin
      best_idx   <= left_idx;
      best_len   <= left_len;
      best_hbase <= left_hbase;
    end
  end

  // table update
  assign is_target = cmd_idx == IDX_W'(CELL_IDX);
  assign is_after  = (CELL_IDX > 0) && (cmd_idx == IDX_W'(CELL_IDX - 1));
  assign is_beyond = (CELL_IDX > 0) && (IDX_W'(CELL_IDX - 1) > cmd_idx)
                     && (CNT_W'(CELL_IDX) <= seg_count);

  always_comb begin
    owner_next  = owner;
    base_next   = base;
    length_next = length;
    unique case (cmd.kind)
      CMD_NONE: begin
      end
      CMD_APPEND: begin
        if (is_target) begin
          owner_next  = cmd.tag;
          base_next   = cmd_addr;
          length_next = cmd.len;
        end
      end
      CMD_EXACT: begin
        if (is_target) begin
          owner_next  = cmd.tag;
          length_next = cmd.len;
        end
      end
      CMD_SPLIT: begin
        priority if (is_target) begin
          length_next = cmd.rest;
        end else if (is_after) begin
          owner_next  = cmd.tag;
          base_next   = cmd_addr;
          length_next = cmd.len;
        end else if (is_beyond) begin
          owner_next  = left_owner;
          base_next   = left_base;
          length_next = left_length;
        end else begin
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    owner  <= owner_next;
    base   <= base_next;
    length <= length_next;
  end

endmodule

// ===== hw/rtl/contiguous_fit_allocator.sv =====
// top level of the contiguous fit allocator: control, result register and cell row
//
//  channel   signals                                  handshake
//  config    cfg_we, cfg_data                         written when cfg_we high
//  request   start, busy, func, owner_tag,            transfer when start && !busy
//            seg_start, amount
//  result    done, status, hole_start,                one cycle strobe on done
//            placed_address
//
// append: the request goes to the apply state and done is registered from it.
// allocate: a scan state precedes the apply state; the best-hole wave moves one
//   cell per cycle along the row, and the scan lasts until it has crossed it.
// a new request is taken in the cycle in which the previous result is shown.
// synchronous reset empties the table and sets first fit; no clearing pass.
// results cannot be stalled by the receiver.
`include "contiguous_fit_allocator_defines.svh"

module contiguous_fit_allocator import cfa_pkg::*; #(
  parameter int MAX_SEGS  = MAX_SEGS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [POL_W-1:0]       cfg_data,
  input  logic                   start,
  output logic                   busy,
  input  logic                   func,
  input  logic [TAG_W-1:0]       owner_tag,
  input  logic [PORT_ADDR_W-1:0] seg_start,
  input  logic [LEN_W-1:0]       amount,
  output logic                   done,
  output logic [1:0]             status,
  output logic [PORT_ADDR_W-1:0] hole_start,
  output logic [PORT_ADDR_W-1:0] placed_address
);

  localparam int IDX_W = $clog2(MAX_SEGS);
  localparam int CNT_W = $clog2(MAX_SEGS + 1);

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       scan_cnt;
  logic [CNT_W-1:0]       seg_count;
  logic [CNT_W-1:0]       seg_count_next;
  logic [POL_W-1:0]       fit_policy;
  logic                   req_func;
  logic [TAG_W-1:0]       req_tag;
  logic [ADDR_BITS-1:0]   req_base;
  logic [LEN_W-1:0]       req_amt;
  status_t                status_q;
  status_t                res_status;
  logic [PORT_ADDR_W-1:0] hole_q;
  logic [PORT_ADDR_W-1:0] res_hole;
  logic [PORT_ADDR_W-1:0] placed_q;
  logic [PORT_ADDR_W-1:0] res_placed;
  logic                   accept;
  logic                   apply;
  logic                   full;
  logic [LEN_W-1:0]       rest;
  logic [ADDR_BITS-1:0]   placed;
  cfa_cmd_t               cmd;
  logic [IDX_W-1:0]       cmd_idx;
  logic [ADDR_BITS-1:0]   cmd_addr;

  logic [TAG_W-1:0]       tab_owner  [MAX_SEGS];
  logic [ADDR_BITS-1:0]   tab_base   [MAX_SEGS];
  logic [LEN_W-1:0]       tab_length [MAX_SEGS];
  logic                   bst_found  [MAX_SEGS];
  logic [IDX_W-1:0]       bst_idx    [MAX_SEGS];
  logic [LEN_W-1:0]       bst_len    [MAX_SEGS];
  logic [ADDR_BITS-1:0]   bst_hbase  [MAX_SEGS];

  // control
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (func == FUNC_APPEND) ? S_APPLY : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_cnt == CNT_W'(1)) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy  = state != S_IDLE;
    apply = state == S_APPLY;
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      scan_cnt   <= '0;
      seg_count  <= '0;
      fit_policy <= POL_FIRST;
      done       <= 1'b0;
    end else begin
      state     <= state_next;
      seg_count <= seg_count_next;
      done      <= apply;
      if (accept) begin
        scan_cnt <= CNT_W'(MAX_SEGS);
      end else if (state == S_SCAN) begin
        scan_cnt <= scan_cnt - CNT_W'(1);
      end
      if (cfg_we) begin
        fit_policy <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func <= func;
      req_tag  <= owner_tag;
      req_base <= ADDR_BITS'(seg_start);
      req_amt  <= amount;
    end
    if (apply) begin
      status_q <= res_status;
      hole_q   <= res_hole;
      placed_q <= res_placed;
    end
  end

  // decision on the search result
  assign full   = seg_count == CNT_W'(MAX_SEGS);
  assign rest   = bst_len[MAX_SEGS-1] - req_amt;
  assign placed = bst_hbase[MAX_SEGS-1] + ADDR_BITS'(rest);

  always_comb begin
    cmd.kind       = CMD_NONE;
    cmd.tag        = req_tag;
    cmd.len        = req_amt;
    cmd.rest       = rest;
    cmd_idx        = bst_idx[MAX_SEGS-1];
    cmd_addr       = placed;
    seg_count_next = seg_count;
    res_status     = STAT_OK;
    res_hole       = '0;
    res_placed     = '0;
    if (apply) begin
      priority if (req_func == FUNC_APPEND) begin
        if (full) begin
          res_status = STAT_FULL;
        end else begin
          cmd.kind       = CMD_APPEND;
          cmd_idx        = seg_count[IDX_W-1:0];
          cmd_addr       = req_base;
          seg_count_next = seg_count + CNT_W'(1);
          res_placed     = PORT_ADDR_W'(req_base);
        end
      end else if (req_amt == '0 || !bst_found[MAX_SEGS-1]) begin
        res_status = STAT_NOFIT;
      end else if (rest == '0) begin
        cmd.kind   = CMD_EXACT;
        res_hole   = PORT_ADDR_W'(bst_hbase[MAX_SEGS-1]);
        res_placed = PORT_ADDR_W'(placed);
      end else if (full) begin
        res_status = STAT_FULL;
        res_hole   = PORT_ADDR_W'(bst_hbase[MAX_SEGS-1]);
      end else begin
        cmd.kind       = CMD_SPLIT;
        seg_count_next = seg_count + CNT_W'(1);
        res_hole       = PORT_ADDR_W'(bst_hbase[MAX_SEGS-1]);
        res_placed     = PORT_ADDR_W'(placed);
      end
    end
  end

  assign status         = status_q;
  assign hole_start     = hole_q;
  assign placed_address = placed_q;

  // cell row
  for (genvar g = 0; g < MAX_SEGS; g++) begin : g_cell
    logic [TAG_W-1:0]     l_owner;
    logic [ADDR_BITS-1:0] l_base;
    logic [LEN_W-1:0]     l_length;
    logic                 l_found;
    logic [IDX_W-1:0]     l_idx;
    logic [LEN_W-1:0]     l_len;
    logic [ADDR_BITS-1:0] l_hbase;

    if (g == 0) begin : g_head
      assign l_owner  = '0;
      assign l_base   = '0;
      assign l_length = '0;
      assign l_found  = 1'b0;
      assign l_idx    = '0;
      assign l_len    = '0;
      assign l_hbase  = '0;
    end else begin : g_link
      assign l_owner  = tab_owner[g-1];
      assign l_base   = tab_base[g-1];
      assign l_length = tab_length[g-1];
      assign l_found  = bst_found[g-1];
      assign l_idx    = bst_idx[g-1];
      assign l_len    = bst_len[g-1];
      assign l_hbase  = bst_hbase[g-1];
    end

    cfa_cell #(
      .CELL_IDX  (g),
      .MAX_SEGS  (MAX_SEGS),
      .ADDR_BITS (ADDR_BITS)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .cmd_idx     (cmd_idx),
      .cmd_addr    (cmd_addr),
      .seg_count   (seg_count),
      .req_len     (req_amt),
      .fit_policy  (fit_policy),
      .left_owner  (l_owner),
      .left_base   (l_base),
      .left_length (l_length),
      .left_found  (l_found),
      .left_idx    (l_idx),
      .left_len    (l_len),
      .left_hbase  (l_hbase),
      .owner       (tab_owner[g]),
      .base        (tab_base[g]),
      .length      (tab_length[g]),
      .best_found  (bst_found[g]),
      .best_idx    (bst_idx[g]),
      .best_len    (bst_len[g]),
      .best_hbase  (bst_hbase[g])
    );
  end

  `CFA_HOLDS(a_count_range, clk, rst, 1'b1, seg_count <= CNT_W'(MAX_SEGS))
  `CFA_NEXT(a_apply_done, clk, rst, state == S_APPLY, done)
  `CFA_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `CFA_HOLDS(a_full_status, clk, rst, done && status_q == STAT_FULL, seg_count == CNT_W'(MAX_SEGS))

endmodule
